[rtl/gbs_pkg.sv]
// Shared types and constants for the greedy box suppression block.
// Payload structs, box storage record, controller command and status.
// No dependencies.
package gbs_pkg;

  localparam int COORD_W = 20;
  localparam int SCORE_W = 16;
  localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 16'd26214;

  typedef struct packed {
    logic signed [COORD_W-1:0] box_left;
    logic signed [COORD_W-1:0] box_top;
    logic signed [COORD_W-1:0] box_right;
    logic signed [COORD_W-1:0] box_bottom;
    logic [SCORE_W-1:0]        box_score;
    logic                      box_present;
    logic                      set_end;
  } box_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] kept_left;
    logic signed [COORD_W-1:0] kept_top;
    logic signed [COORD_W-1:0] kept_right;
    logic signed [COORD_W-1:0] kept_bottom;
    logic [SCORE_W-1:0]        kept_score;
    logic                      run_last;
    logic                      set_empty;
    logic                      overflowed;
  } box_out_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic [SCORE_W-1:0]        score;
  } box_rec_t;

  typedef struct packed {
    logic box_we;
    logic raddr_from_ord;
    logic ord_we;
    logic load_si;
    logic load_a;
    logic mark_set;
    logic marks_clr;
    logic out_load;
    logic out_empty;
    logic out_last;
    logic out_ovf;
  } dp_cmd_t;

  typedef struct packed {
    logic score_gt;
    logic score_eq;
    logic marked;
    logic suppress;
  } dp_sts_t;

endpackage

[rtl/gbs_datapath.sv]
// Datapath: box and order memories, suppression marks, overlap pipeline,
// threshold register and result register. Uses gbs_pkg.
module gbs_datapath #(
  parameter int MAX_BOXES = 64,
  parameter int IDX_W = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        threshold_we,
  input  logic [gbs_pkg::SCORE_W-1:0] threshold_data,
  input  gbs_pkg::box_in_t            box_data,
  input  logic [IDX_W-1:0]            box_waddr,
  input  logic [IDX_W-1:0]            box_raddr,
  input  logic [IDX_W-1:0]            ord_raddr,
  input  logic [IDX_W-1:0]            ord_waddr,
  input  logic [IDX_W-1:0]            ord_wdata,
  input  logic [IDX_W-1:0]            mark_idx,
  input  gbs_pkg::dp_cmd_t            cmd,
  output gbs_pkg::dp_sts_t            sts,
  output gbs_pkg::box_out_t           kept_data
);

  gbs_pkg::box_rec_t box_mem [MAX_BOXES];
  gbs_pkg::box_rec_t box_q;
  gbs_pkg::box_rec_t a;
  logic [IDX_W-1:0] ord_mem [MAX_BOXES];
  logic [IDX_W-1:0] ord_q;
  logic [IDX_W-1:0] rd_addr;
  logic [gbs_pkg::SCORE_W-1:0] si;
  logic [gbs_pkg::SCORE_W-1:0] threshold;
  logic [MAX_BOXES-1:0] marks;
  gbs_pkg::box_out_t kept_next;

  logic signed [gbs_pkg::COORD_W-1:0] l_max, t_max, r_min, b_min;
  logic signed [gbs_pkg::COORD_W:0] w_d, h_d, dxb, dyb, dxa, dya;
  logic [gbs_pkg::COORD_W-1:0] w_r, h_r;
  logic signed [gbs_pkg::COORD_W:0] dxb_r, dyb_r;
  logic [2*gbs_pkg::COORD_W-1:0] inter_r, inter2_r;
  logic signed [2*gbs_pkg::COORD_W+1:0] areab_r, areaa_r;
  logic signed [2*gbs_pkg::COORD_W+3:0] uni_r;
  logic uni_pos_r;
  logic [2*gbs_pkg::COORD_W+18:0] prod_r;
  logic [2*gbs_pkg::COORD_W+15:0] inter_sh_r;

  assign rd_addr = cmd.raddr_from_ord ? ord_q : box_raddr;

  always_ff @(posedge clk) begin
    if (cmd.box_we) begin
      box_mem[box_waddr] <= '{box_data.box_left, box_data.box_top, box_data.box_right,
                              box_data.box_bottom, box_data.box_score};
    end
    box_q <= box_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_q <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_si) begin
      si <= box_q.score;
    end
    if (cmd.load_a) begin
      a <= box_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= gbs_pkg::THRESHOLD_RESET;
      marks <= '0;
    end else begin
      if (threshold_we) begin
        threshold <= threshold_data;
      end
      if (cmd.marks_clr) begin
        marks <= '0;
      end else if (cmd.mark_set) begin
        marks[mark_idx] <= 1'b1;
      end
    end
  end

  always_comb begin
    l_max = (a.left > box_q.left) ? a.left : box_q.left;
    t_max = (a.top > box_q.top) ? a.top : box_q.top;
    r_min = (a.right < box_q.right) ? a.right : box_q.right;
    b_min = (a.bottom < box_q.bottom) ? a.bottom : box_q.bottom;
    w_d = {r_min[gbs_pkg::COORD_W-1], r_min} - {l_max[gbs_pkg::COORD_W-1], l_max};
    h_d = {b_min[gbs_pkg::COORD_W-1], b_min} - {t_max[gbs_pkg::COORD_W-1], t_max};
    dxb = {box_q.right[gbs_pkg::COORD_W-1], box_q.right}
        - {box_q.left[gbs_pkg::COORD_W-1], box_q.left};
    dyb = {box_q.bottom[gbs_pkg::COORD_W-1], box_q.bottom}
        - {box_q.top[gbs_pkg::COORD_W-1], box_q.top};
    dxa = {a.right[gbs_pkg::COORD_W-1], a.right} - {a.left[gbs_pkg::COORD_W-1], a.left};
    dya = {a.bottom[gbs_pkg::COORD_W-1], a.bottom} - {a.top[gbs_pkg::COORD_W-1], a.top};
  end

  // overlap pipeline, four register stages
  always_ff @(posedge clk) begin
    w_r <= w_d[gbs_pkg::COORD_W] ? '0 : w_d[gbs_pkg::COORD_W-1:0];
    h_r <= h_d[gbs_pkg::COORD_W] ? '0 : h_d[gbs_pkg::COORD_W-1:0];
    dxb_r <= dxb;
    dyb_r <= dyb;
    areaa_r <= dxa * dya;
    inter_r <= w_r * h_r;
    areab_r <= dxb_r * dyb_r;
    inter2_r <= inter_r;
    uni_r <= {{2{areaa_r[2*gbs_pkg::COORD_W+1]}}, areaa_r}
           + {{2{areab_r[2*gbs_pkg::COORD_W+1]}}, areab_r}
           - {4'b0, inter_r};
    inter_sh_r <= {inter2_r, 16'b0};
    uni_pos_r <= uni_r > 0;
    prod_r <= threshold * uni_r[2*gbs_pkg::COORD_W+2:0];
  end

  always_comb begin
    sts.score_gt = box_q.score > si;
    sts.score_eq = box_q.score == si;
    sts.marked = marks[mark_idx];
    sts.suppress = uni_pos_r && ({3'b0, inter_sh_r} > prod_r);
  end

  always_comb begin
    kept_next = '0;
    if (cmd.out_empty) begin
      kept_next.run_last = 1'b1;
      kept_next.set_empty = 1'b1;
    end else begin
      kept_next.kept_left = a.left;
      kept_next.kept_top = a.top;
      kept_next.kept_right = a.right;
      kept_next.kept_bottom = a.bottom;
      kept_next.kept_score = a.score;
      kept_next.run_last = cmd.out_last;
    end
    kept_next.overflowed = cmd.out_ovf;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kept_data <= kept_next;
    end
  end

endmodule

[rtl/gbs_ctrl.sv]
// Controller: load counting, rank sort sequencing, suppression walk and
// result handshake. Drives gbs_datapath through gbs_pkg command/status.
module gbs_ctrl #(
  parameter int MAX_BOXES = 64,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                box_valid,
  output logic                box_ready,
  input  logic                box_present,
  input  logic                set_end,
  output logic                kept_valid,
  input  logic                kept_ready,
  output logic [IDX_W-1:0]    box_waddr,
  output logic [IDX_W-1:0]    box_raddr,
  output logic [IDX_W-1:0]    ord_raddr,
  output logic [IDX_W-1:0]    ord_waddr,
  output logic [IDX_W-1:0]    ord_wdata,
  output logic [IDX_W-1:0]    mark_idx,
  output gbs_pkg::dp_cmd_t    cmd,
  input  gbs_pkg::dp_sts_t    sts
);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_RK_I   = 16'h0002,
    S_RK_SI  = 16'h0004,
    S_RK_RD  = 16'h0008,
    S_RK_CMP = 16'h0010,
    S_RK_WR  = 16'h0020,
    S_OUTER  = 16'h0040,
    S_A_ORD  = 16'h0080,
    S_A_BOX  = 16'h0100,
    S_INNER  = 16'h0200,
    S_P_BOX  = 16'h0400,
    S_P_WAIT = 16'h0800,
    S_P_CMP  = 16'h1000,
    S_EMIT   = 16'h2000,
    S_EMPTY  = 16'h4000,
    S_FINISH = 16'h8000
  } state_t;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BOXES);

  state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next, i, i_next, j, j_next, rank, rank_next;
  logic [CNT_W-1:0] i_inc, j_inc, cnt_after;
  logic [1:0] wcnt, wcnt_next;
  logic ovf, ovf_next, remaining, remaining_next;
  logic accept, store;

  assign i_inc = i + 1'b1;
  assign j_inc = j + 1'b1;
  assign accept = box_valid && box_ready;
  assign store = accept && box_present && (cnt < MAX_CNT);
  assign cnt_after = store ? cnt + 1'b1 : cnt;

  assign box_ready = state == S_IDLE;
  assign kept_valid = (state == S_EMIT) || (state == S_EMPTY);
  assign box_waddr = cnt[IDX_W-1:0];
  assign ord_waddr = rank[IDX_W-1:0];
  assign ord_wdata = i[IDX_W-1:0];
  assign ord_raddr = (state == S_OUTER) ? i[IDX_W-1:0] : j[IDX_W-1:0];
  assign mark_idx = (state == S_OUTER) ? i[IDX_W-1:0] : j[IDX_W-1:0];
  assign box_raddr = (state == S_RK_I) ? i[IDX_W-1:0] : j[IDX_W-1:0];

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    ovf_next = ovf;
    i_next = i;
    j_next = j;
    rank_next = rank;
    wcnt_next = wcnt;
    remaining_next = remaining;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.box_we = store;
          cnt_next = cnt_after;
          if (box_present && !store) ovf_next = 1'b1;
          if (set_end) begin
            if (cnt_after == '0) begin
              cmd.out_load = 1'b1;
              cmd.out_empty = 1'b1;
              state_next = S_EMPTY;
            end else begin
              i_next = '0;
              state_next = S_RK_I;
            end
          end
        end
      end
      S_RK_I: state_next = S_RK_SI;
      S_RK_SI: begin
        cmd.load_si = 1'b1;
        j_next = '0;
        rank_next = '0;
        state_next = S_RK_RD;
      end
      S_RK_RD: state_next = S_RK_CMP;
      S_RK_CMP: begin
        if (sts.score_gt || (sts.score_eq && (j < i))) rank_next = rank + 1'b1;
        j_next = j_inc;
        if (j_inc == cnt) state_next = S_RK_WR;
        else state_next = S_RK_RD;
      end
      S_RK_WR: begin
        cmd.ord_we = 1'b1;
        if (i_inc == cnt) begin
          i_next = '0;
          state_next = S_OUTER;
        end else begin
          i_next = i_inc;
          state_next = S_RK_I;
        end
      end
      S_OUTER: begin
        if (i == cnt) state_next = S_FINISH;
        else if (sts.marked) i_next = i_inc;
        else state_next = S_A_ORD;
      end
      S_A_ORD: begin
        cmd.raddr_from_ord = 1'b1;
        state_next = S_A_BOX;
      end
      S_A_BOX: begin
        cmd.load_a = 1'b1;
        j_next = i_inc;
        remaining_next = 1'b0;
        state_next = S_INNER;
      end
      S_INNER: begin
        if (j == cnt) begin
          cmd.out_load = 1'b1;
          cmd.out_last = !remaining;
          state_next = S_EMIT;
        end else if (sts.marked) begin
          j_next = j_inc;
        end else begin
          state_next = S_P_BOX;
        end
      end
      S_P_BOX: begin
        cmd.raddr_from_ord = 1'b1;
        wcnt_next = '0;
        state_next = S_P_WAIT;
      end
      S_P_WAIT: begin
        wcnt_next = wcnt + 1'b1;
        if (wcnt == 2'd3) state_next = S_P_CMP;
      end
      S_P_CMP: begin
        if (sts.suppress) cmd.mark_set = 1'b1;
        else remaining_next = 1'b1;
        j_next = j_inc;
        state_next = S_INNER;
      end
      S_EMIT: begin
        if (kept_ready) begin
          i_next = i_inc;
          state_next = S_OUTER;
        end
      end
      S_EMPTY: begin
        if (kept_ready) state_next = S_FINISH;
      end
      S_FINISH: begin
        cmd.marks_clr = 1'b1;
        cnt_next = '0;
        ovf_next = 1'b0;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    cmd.out_ovf = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      ovf <= 1'b0;
      i <= '0;
      j <= '0;
      rank <= '0;
      wcnt <= '0;
      remaining <= 1'b0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      ovf <= ovf_next;
      i <= i_next;
      j <= j_next;
      rank <= rank_next;
      wcnt <= wcnt_next;
      remaining <= remaining_next;
    end
  end

  a_store_count: assert property (@(posedge clk) disable iff (rst)
    store |=> cnt == $past(cnt) + 1'b1)
    else $error("box count did not advance on store");

  a_empty_set: assert property (@(posedge clk) disable iff (rst)
    (accept && set_end && cnt_after == '0) |=> state == S_EMPTY)
    else $error("empty set did not produce empty result");

  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RK_WR |-> (rank < cnt && i < cnt))
    else $error("rank out of range");

  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    state == S_P_CMP |-> (j < cnt && j > i))
    else $error("pair index out of range");

endmodule

[rtl/greedy_box_suppression.sv]
// Greedy box suppression, top level: controller plus datapath.
// Uses gbs_pkg, gbs_ctrl and gbs_datapath.
//
// Boxes are loaded one per cycle until the transaction marked set_end. The
// set is then ranked by score, each box compared with every box of the set,
// itself included, through the single read port of the box memory. The
// suppression walk then runs every remaining pair through a four-stage
// overlap pipeline, one pair at a time, and waits for each result to be taken.
// Input is accepted only between sets.
module greedy_box_suppression #(
  parameter int MAX_BOXES = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        box_valid,
  output logic                        box_ready,
  input  gbs_pkg::box_in_t            box_data,
  output logic                        kept_valid,
  input  logic                        kept_ready,
  output gbs_pkg::box_out_t           kept_data,
  input  logic                        threshold_we,
  input  logic [gbs_pkg::SCORE_W-1:0] threshold_data
);

  localparam int IDX_W = $clog2(MAX_BOXES);
  localparam int CNT_W = $clog2(MAX_BOXES + 1);

  logic [IDX_W-1:0] box_waddr, box_raddr, ord_raddr, ord_waddr, ord_wdata, mark_idx;
  gbs_pkg::dp_cmd_t cmd;
  gbs_pkg::dp_sts_t sts;

  gbs_ctrl #(
    .MAX_BOXES(MAX_BOXES),
    .IDX_W(IDX_W),
    .CNT_W(CNT_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .box_valid(box_valid),
    .box_ready(box_ready),
    .box_present(box_data.box_present),
    .set_end(box_data.set_end),
    .kept_valid(kept_valid),
    .kept_ready(kept_ready),
    .box_waddr(box_waddr),
    .box_raddr(box_raddr),
    .ord_raddr(ord_raddr),
    .ord_waddr(ord_waddr),
    .ord_wdata(ord_wdata),
    .mark_idx(mark_idx),
    .cmd(cmd),
    .sts(sts)
  );

  gbs_datapath #(
    .MAX_BOXES(MAX_BOXES),
    .IDX_W(IDX_W)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .threshold_we(threshold_we),
    .threshold_data(threshold_data),
    .box_data(box_data),
    .box_waddr(box_waddr),
    .box_raddr(box_raddr),
    .ord_raddr(ord_raddr),
    .ord_waddr(ord_waddr),
    .ord_wdata(ord_wdata),
    .mark_idx(mark_idx),
    .cmd(cmd),
    .sts(sts),
    .kept_data(kept_data)
  );

endmodule
